// ===== src/vup_pkg.sv =====
// shared types and constants of the vector unpack engine
`default_nettype none

package vup_pkg;

    localparam int LANES      = 4;
    localparam int LANE_W     = 32;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 136;
    localparam int QUEUE_DEPTH = 2;

    // element size codes of a header
    localparam logic [1:0] SIZE_32     = 2'd0;
    localparam logic [1:0] SIZE_16     = 2'd1;
    localparam logic [1:0] SIZE_8      = 2'd2;
    localparam logic [1:0] SIZE_COLOUR = 2'd3;

    // item kind carried on tuser
    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_DATA   = 1'b1;

    // component code that a colour run requires
    localparam logic [1:0] COMP_FOUR = 2'd3;

    // one queue entry: a run header or a data word split into elements
    typedef struct packed {
        logic                          is_header;
        logic [8:0]                    vcount;     // vectors in run, 0 = invalid run
        logic [1:0]                    comps;      // components minus one
        logic                          colour;     // 5-5-5-1 run
        logic [1:0]                    last_idx;   // index of the last element in word
        logic [LANES-1:0][LANE_W-1:0]  elems;      // extended elements, first at 0
    } vup_entry_t;

endpackage

`default_nettype wire

// ===== src/vup_front.sv =====
// front end: accepts items, tracks the run format and splits data words
`default_nettype none

module vup_front
    import vup_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tuser,
    input  wire logic [31:0] data_word,
    input  wire logic [1:0]  component_code,
    input  wire logic [1:0]  elem_size_code,
    input  wire logic        zero_extend,
    input  wire logic [7:0]  vector_count,
    input  wire logic        queue_full,
    output logic             s_tready,
    output logic             push,
    output vup_entry_t       push_entry
);

    logic [1:0] size_reg, size_next;
    logic [1:0] comps_reg, comps_next;
    logic       zext_reg, zext_next;
    logic       run_ok_reg, run_ok_next;

    logic       accept;
    logic       hdr_invalid;

    function automatic logic [31:0] ext16(logic [15:0] v, logic zx);
        ext16 = {{16{v[15] & ~zx}}, v};
    endfunction

    function automatic logic [31:0] ext8(logic [7:0] v, logic zx);
        ext8 = {{24{v[7] & ~zx}}, v};
    endfunction

    assign s_tready    = ~queue_full;
    assign accept      = s_tvalid & s_tready;
    assign hdr_invalid = (elem_size_code == SIZE_COLOUR) && (component_code != COMP_FOUR);

    always_comb begin
        size_next   = size_reg;
        comps_next  = comps_reg;
        zext_next   = zext_reg;
        run_ok_next = run_ok_reg;
        if (accept && s_tuser == MODE_HEADER) begin
            size_next   = elem_size_code;
            comps_next  = component_code;
            zext_next   = zero_extend;
            run_ok_next = ~hdr_invalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg   <= SIZE_32;
            comps_reg  <= 2'd0;
            zext_reg   <= 1'b0;
            run_ok_reg <= 1'b0;
        end else begin
            size_reg   <= size_next;
            comps_reg  <= comps_next;
            zext_reg   <= zext_next;
            run_ok_reg <= run_ok_next;
        end
    end

    always_comb begin
        push_entry           = '0;
        push_entry.is_header = (s_tuser == MODE_HEADER);
        if (s_tuser == MODE_HEADER) begin
            push_entry.vcount = hdr_invalid ? 9'd0 : {vector_count == 8'd0, vector_count};
            push_entry.comps  = component_code;
            push_entry.colour = (elem_size_code == SIZE_COLOUR);
        end else begin
            push_entry.comps  = comps_reg;
            push_entry.colour = (size_reg == SIZE_COLOUR);
            case (size_reg)
                SIZE_32: begin
                    push_entry.last_idx = 2'd0;
                    push_entry.elems[0] = data_word;
                end
                SIZE_16: begin
                    push_entry.last_idx = 2'd1;
                    push_entry.elems[0] = ext16(data_word[15:0], zext_reg);
                    push_entry.elems[1] = ext16(data_word[31:16], zext_reg);
                end
                SIZE_8: begin
                    push_entry.last_idx = 2'd3;
                    push_entry.elems[0] = ext8(data_word[7:0], zext_reg);
                    push_entry.elems[1] = ext8(data_word[15:8], zext_reg);
                    push_entry.elems[2] = ext8(data_word[23:16], zext_reg);
                    push_entry.elems[3] = ext8(data_word[31:24], zext_reg);
                end
                default: begin
                    push_entry.last_idx = 2'd1;
                    push_entry.elems[0] = {16'd0, data_word[15:0]};
                    push_entry.elems[1] = {16'd0, data_word[31:16]};
                end
            endcase
        end
    end

    // data with no valid run is dropped here
    assign push = accept && ((s_tuser == MODE_HEADER) || run_ok_reg);

endmodule

`default_nettype wire

// ===== src/vup_queue.sv =====
// two-entry queue between the front and back ends
`default_nettype none

module vup_queue
    import vup_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire vup_entry_t push_entry,
    input  wire logic       pop,
    output logic            full,
    output logic            head_valid,
    output vup_entry_t      head_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    vup_entry_t             store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;
    logic                   do_push, do_pop;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = store_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/vup_back.sv =====
// back end: assembles vectors one element per cycle unless stalled on output
`default_nettype none

module vup_back
    import vup_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     head_valid,
    input  wire vup_entry_t               head_entry,
    output logic                          pop,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [LANES-1:0][LANE_W-1:0]  lanes,
    output logic [7:0]                    vector_index,
    output logic                          m_tlast
);

    logic [8:0]              vl_reg, vl_next;
    logic [7:0]              done_reg, done_next;
    logic [1:0]              comps_reg, comps_next;
    logic                    colour_reg, colour_next;
    logic [1:0]              pc_reg, pc_next;
    logic [1:0]              idx_reg, idx_next;
    logic [LANE_W-1:0]       pend_reg [3];
    logic                    out_valid_reg, out_valid_next;
    logic [LANES-1:0][LANE_W-1:0] lanes_reg;
    logic [7:0]              index_reg;
    logic                    last_reg;

    logic [LANE_W-1:0]       elem;
    logic                    is_data, run_on, emit_req, out_free, stall, work, fire, store;
    logic [LANES-1:0][LANE_W-1:0] lanes_new;

    assign elem     = head_entry.elems[idx_reg];
    assign is_data  = head_valid & ~head_entry.is_header;
    assign run_on   = (vl_reg != 9'd0);
    assign emit_req = is_data && run_on && (colour_reg || comps_reg == 2'd0 || pc_reg == comps_reg);
    assign out_free = ~out_valid_reg | m_tready;
    assign stall    = emit_req & ~out_free;
    assign work     = is_data & run_on & ~stall;
    assign fire     = work & emit_req;
    assign store    = work & ~emit_req;
    assign pop      = head_valid && !stall &&
                      (head_entry.is_header || !run_on || idx_reg == head_entry.last_idx ||
                       (fire && vl_reg == 9'd1));

    always_comb begin
        lanes_new = '0;
        if (colour_reg) begin
            lanes_new[0] = {24'd0, elem[4:0], 3'd0};
            lanes_new[1] = {24'd0, elem[9:5], 3'd0};
            lanes_new[2] = {24'd0, elem[14:10], 3'd0};
            lanes_new[3] = {24'd0, elem[15], 7'd0};
        end else if (comps_reg == 2'd0) begin
            for (int k = 0; k < LANES; k++) begin
                lanes_new[k] = elem;
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < pc_reg) begin
                    lanes_new[k] = pend_reg[k];
                end
            end
            lanes_new[pc_reg] = elem;
        end
    end

    always_comb begin
        vl_next     = vl_reg;
        done_next   = done_reg;
        comps_next  = comps_reg;
        colour_next = colour_reg;
        pc_next     = pc_reg;
        idx_next    = idx_reg;
        if (head_valid && head_entry.is_header) begin
            vl_next     = head_entry.vcount;
            comps_next  = head_entry.comps;
            colour_next = head_entry.colour;
            done_next   = 8'd0;
            pc_next     = 2'd0;
        end
        if (store) begin
            pc_next = pc_reg + 1'b1;
        end
        if (fire) begin
            vl_next   = vl_reg - 1'b1;
            done_next = done_reg + 1'b1;
            pc_next   = 2'd0;
        end
        if (pop) begin
            idx_next = 2'd0;
        end else if (work) begin
            idx_next = idx_reg + 1'b1;
        end
        out_valid_next = out_valid_reg & ~m_tready;
        if (fire) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_reg        <= 9'd0;
            done_reg      <= 8'd0;
            comps_reg     <= 2'd0;
            colour_reg    <= 1'b0;
            pc_reg        <= 2'd0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            vl_reg        <= vl_next;
            done_reg      <= done_next;
            comps_reg     <= comps_next;
            colour_reg    <= colour_next;
            pc_reg        <= pc_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            pend_reg[pc_reg] <= elem;
        end
        if (fire) begin
            lanes_reg <= lanes_new;
            index_reg <= done_reg;
            last_reg  <= (vl_reg == 9'd1);
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign lanes        = lanes_reg;
    assign vector_index = index_reg;
    assign m_tlast      = last_reg;

endmodule

`default_nettype wire

// ===== src/vector_unpack_engine.sv =====
// top level of the vector unpack engine: front end, queue and back end
`default_nettype none

// unpacks a stream of packed 32-bit words into four-lane vectors. a header
// transaction (tuser low) starts a run with its component count, element size,
// extension and vector count; data transactions (tuser high) follow. the front
// end takes one transaction per cycle while the two-entry queue has room and
// splits each data word into its elements; the back end turns one element into
// lane state or a vector per cycle, stalling when a vector finds the output
// register full; a data word holds one 32-bit element, two 16-bit or colour
// elements or four 8-bit elements. one vector leaves per cycle at most through
// the output register, and tlast marks the last vector of each run. data words
// with no active run produce nothing.

module vector_unpack_engine
    import vup_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input transactions
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // data_word [31:0], component_code [33:32], elem_size_code [35:34],
    // zero_extend [36], vector_count [44:37], zero pad [47:45]
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // mode [0]: 0 header, 1 data word
    input  wire logic                 s_tuser,
    // result transactions
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // lane_x [31:0], lane_y [63:32], lane_z [95:64], lane_w [127:96],
    // vector_index [135:128]
    output logic [M_DATA_W-1:0]       m_tdata,
    // last [0]: final vector of the run
    output logic                      m_tlast
);

    vup_entry_t push_entry, head_entry;
    logic       push, pop, queue_full, head_valid;
    logic [LANES-1:0][LANE_W-1:0] lanes;
    logic [7:0] vector_index;

    // classification and element split
    vup_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tuser        (s_tuser),
        .data_word      (s_tdata[31:0]),
        .component_code (s_tdata[33:32]),
        .elem_size_code (s_tdata[35:34]),
        .zero_extend    (s_tdata[36]),
        .vector_count   (s_tdata[44:37]),
        .queue_full     (queue_full),
        .s_tready       (s_tready),
        .push           (push),
        .push_entry     (push_entry)
    );

    // decouples input acceptance from vector assembly
    vup_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // vector assembly and output register
    vup_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .lanes        (lanes),
        .vector_index (vector_index),
        .m_tlast      (m_tlast)
    );

    assign m_tdata = {vector_index, lanes[3], lanes[2], lanes[1], lanes[0]};

endmodule

`default_nettype wire
